// ===== rtl/paht_pkg.sv =====
// ----------------------------------------------------------------------------
// paht_pkg
// Types, codes and sizing constants shared by the pair accumulate hash table.
// ----------------------------------------------------------------------------
package paht_pkg;

  localparam int CAPACITY   = 1024;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = IDX_W + 1;
  // a new key is refused once (entries + 1) * 10 >= CAPACITY * 7
  localparam int LOAD_LIMIT = (CAPACITY * 7 - 1) / 10;

  localparam logic [63:0] FIB_MULT = 64'h9E37_79B9_7F4A_7C15;

  localparam int S_FIELDS_W = 2 + 32 + 32 + 32;
  localparam int S_TDATA_W  = (S_FIELDS_W + 7) / 8 * 8;
  localparam int M_FIELDS_W = 3 + 48 + 32;
  localparam int M_TDATA_W  = (M_FIELDS_W + 7) / 8 * 8;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_FIND  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] STAT_UPDATED  = 3'd0;
  localparam logic [2:0] STAT_INSERTED = 3'd1;
  localparam logic [2:0] STAT_NOTFOUND = 3'd2;
  localparam logic [2:0] STAT_FULL     = 3'd3;
  localparam logic [2:0] STAT_CLEARED  = 3'd4;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_UPDATE,
    S_CLEAR,
    S_REPLY
  } back_state_t;

  typedef struct packed {
    logic        used;
    logic [63:0] key;
    logic [47:0] sum;
    logic [31:0] count;
  } entry_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [63:0]      key;
    logic [IDX_W-1:0] home;
    logic [31:0]      amt;
  } queue_item_t;

  typedef struct packed {
    logic             init_busy;
    logic [CNT_W-1:0] entries;
  } back_stat_t;

endpackage

// ===== rtl/paht_ram.sv =====
// ----------------------------------------------------------------------------
// paht_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module paht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/paht_front.sv =====
// ----------------------------------------------------------------------------
// paht_front
// Accepts commands, orders the pair into a key, hashes the home slot and
// holds the result in a two-entry queue for the table engine.
// ----------------------------------------------------------------------------
module paht_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // opcode[1:0], item_a[33:2], item_b[65:34], utility_amount[97:66]
  input  logic [paht_pkg::S_TDATA_W-1:0] s_tdata,
  input  paht_pkg::back_stat_t          stat,
  output logic                          q_valid,
  output paht_pkg::queue_item_t         q_item,
  input  logic                          q_pop
);
  import paht_pkg::*;

  logic [1:0]         opcode;
  logic [31:0]        item_a;
  logic [31:0]        item_b;
  logic [31:0]        lo_id;
  logic [31:0]        hi_id;
  logic [2*IDX_W-1:0] hash_prod;
  queue_item_t        push_item;
  logic               push;

  queue_item_t fifo [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign opcode = s_tdata[1:0];
  assign item_a = s_tdata[33:2];
  assign item_b = s_tdata[65:34];
  assign lo_id  = (item_a < item_b) ? item_a : item_b;
  assign hi_id  = (item_a < item_b) ? item_b : item_a;

  // only the low index bits of key * FIB_MULT are kept
  assign hash_prod = hi_id[IDX_W-1:0] * FIB_MULT[IDX_W-1:0];

  assign push_item.op   = opcode;
  assign push_item.key  = {lo_id, hi_id};
  assign push_item.home = hash_prod[IDX_W-1:0];
  assign push_item.amt  = s_tdata[97:66];

  assign s_tready = !stat.init_busy && (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/paht_back.sv =====
// ----------------------------------------------------------------------------
// paht_back
// Table engine: linear probe, read-modify-write of the slot entry, clear
// sweep, and the result register.
// ----------------------------------------------------------------------------
module paht_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  paht_pkg::queue_item_t         q_item,
  output logic                          q_pop,
  output paht_pkg::back_stat_t          stat,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status[2:0], utility_sum[50:3], pair_count[82:51]
  output logic [paht_pkg::M_TDATA_W-1:0] m_tdata
);
  import paht_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [1:0]       op;
  logic [63:0]      key;
  logic [31:0]      amt;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] clr_idx;
  logic [CNT_W-1:0] entry_total;
  logic             found;
  logic [47:0]      old_sum;
  logic [31:0]      old_cnt;
  logic [2:0]       res_status;
  logic [47:0]      res_sum;
  logic [31:0]      res_cnt;
  logic [2:0]       out_status;
  logic [47:0]      out_sum;
  logic [31:0]      out_cnt;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_ent;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_ent;

  logic             probe_next;
  logic             full;
  logic             clr_last;
  logic             can_load;
  logic [48:0]      sum_wide;
  logic [47:0]      new_sum;
  logic [31:0]      new_cnt;
  entry_t           upd_ent;

  paht_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_ent),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_ent)
  );

  assign probe_next = rd_ent.used && (rd_ent.key != key);
  assign full       = (entry_total >= CNT_W'(LOAD_LIMIT));
  assign clr_last   = (clr_idx == {IDX_W{1'b1}});
  assign can_load   = !m_tvalid || m_tready;

  assign sum_wide = {1'b0, old_sum} + {17'd0, amt};
  always_comb begin
    if (found) begin
      new_sum = sum_wide[48] ? {48{1'b1}} : sum_wide[47:0];
      new_cnt = (old_cnt == {32{1'b1}}) ? old_cnt : old_cnt + 32'd1;
    end else begin
      new_sum = {16'd0, amt};
      new_cnt = 32'd1;
    end
  end

  assign upd_ent.used  = 1'b1;
  assign upd_ent.key   = key;
  assign upd_ent.sum   = new_sum;
  assign upd_ent.count = new_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = pos;
    wr_en      = 1'b0;
    wr_addr    = pos;
    wr_ent     = upd_ent;
    case (state)
      S_INIT, S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_ent  = '0;
        if (clr_last) begin
          state_next = (state == S_INIT) ? S_IDLE : S_REPLY;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.op)
            OP_ADD, OP_FIND: state_next = S_READ;
            OP_CLEAR:        state_next = S_CLEAR;
            default:         state_next = S_REPLY;
          endcase
        end
      end
      S_READ: begin
        rd_en      = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (probe_next) begin
          rd_en   = 1'b1;
          rd_addr = pos + 1'b1;
        end else begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        wr_en      = (op == OP_ADD) && (found || !full);
        state_next = S_REPLY;
      end
      S_REPLY: begin
        if (can_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          op         <= q_item.op;
          key        <= q_item.key;
          amt        <= q_item.amt;
          pos        <= q_item.home;
          res_status <= STAT_NOTFOUND;
          res_sum    <= '0;
          res_cnt    <= '0;
        end
      end
      S_CHECK: begin
        if (probe_next) begin
          pos <= pos + 1'b1;
        end else begin
          found   <= rd_ent.used;
          old_sum <= rd_ent.sum;
          old_cnt <= rd_ent.count;
        end
      end
      S_UPDATE: begin
        if (op == OP_FIND) begin
          if (found) begin
            res_status <= STAT_UPDATED;
            res_sum    <= old_sum;
            res_cnt    <= old_cnt;
          end
        end else if (found) begin
          res_status <= STAT_UPDATED;
          res_sum    <= new_sum;
          res_cnt    <= new_cnt;
        end else if (!full) begin
          res_status <= STAT_INSERTED;
          res_sum    <= new_sum;
          res_cnt    <= new_cnt;
        end else begin
          res_status <= STAT_FULL;
        end
      end
      S_CLEAR: begin
        if (clr_last) begin
          res_status <= STAT_CLEARED;
        end
      end
      S_REPLY: begin
        if (can_load) begin
          out_status <= res_status;
          out_sum    <= res_sum;
          out_cnt    <= res_cnt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx     <= '0;
      entry_total <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (state == S_INIT || state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_last) begin
          entry_total <= '0;
        end
      end
      if (state == S_UPDATE && op == OP_ADD && !found && !full) begin
        entry_total <= entry_total + 1'b1;
      end
      if (state == S_REPLY && can_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_cnt, out_sum, out_status};

  assign stat.init_busy = (state == S_INIT);
  assign stat.entries   = entry_total;

endmodule

// ===== rtl/pair_accumulate_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// pair_accumulate_hash_table_core
// Open-addressing hash table of unordered item-id pairs with saturating
// utility sums and counts, linear probing from a Fibonacci-hashed home slot.
// ----------------------------------------------------------------------------
//  channel  dir  fields (low bit up)
//  s_*      in   opcode, item_a, item_b, utility_amount
//  m_*      out  status, utility_sum, pair_count
//
// Add/find: a read of the home slot, one more read per extra probe through
// the single read port of the slot RAM, then update and reply. Clear: one
// slot written per cycle. After reset the slot RAM is swept; s_tready is low.
// Two commands queue ahead of the engine; a held result stalls only it.
// ----------------------------------------------------------------------------
module pair_accumulate_hash_table_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // opcode[1:0], item_a[33:2], item_b[65:34], utility_amount[97:66]
  input  logic [paht_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status[2:0], utility_sum[50:3], pair_count[82:51]
  output logic [paht_pkg::M_TDATA_W-1:0] m_tdata
);
  import paht_pkg::*;

  logic        q_valid;
  logic        q_pop;
  queue_item_t q_item;
  back_stat_t  stat;

  paht_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .stat    (stat),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  paht_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .stat    (stat),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

`ifndef SYNTHESIS
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_load_limit: assert property (@(posedge clk) disable iff (rst)
    stat.entries <= CNT_W'(LOAD_LIMIT))
    else $error("entry count above load limit");

  a_no_accept_in_init: assert property (@(posedge clk) disable iff (rst)
    stat.init_busy |-> !s_tready)
    else $error("command accepted during init sweep");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    $fell(stat.init_busy) |-> stat.entries == '0)
    else $error("entries not zero after init sweep");
`endif

endmodule

// ===== sim/pair_table_monitor.sv =====
// ----------------------------------------------------------------------------
// pair_table_monitor
// Watches both stream channels of the pair accumulate hash table, keeps its
// own copy of the table to predict each reply, and compares every reply
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pair_table_monitor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  // opcode[1:0], item_a[33:2], item_b[65:34], utility_amount[97:66]
  input  logic [paht_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // status[2:0], utility_sum[50:3], pair_count[82:51]
  input  logic [paht_pkg::M_TDATA_W-1:0] m_tdata,
  output int                             mismatches,
  output int                             outstanding,
  output int                             refusals
);
  timeunit 1ns;
  timeprecision 1ps;

  import paht_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] sum;
    logic [31:0] count;
  } reply_t;

  logic [63:0] stored_key   [CAPACITY];
  logic [47:0] stored_sum   [CAPACITY];
  logic [31:0] stored_count [CAPACITY];
  bit          occupied     [CAPACITY];
  int          live_entries;
  int          fail_total;
  int          refusal_total;
  reply_t      expected_replies[$];

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    refusals      = 0;
    fail_total    = 0;
    refusal_total = 0;
    live_entries  = 0;
  end

  function automatic reply_t predict_table_op(input logic [1:0] op, input logic [31:0] a,
                                              input logic [31:0] b, input logic [31:0] amt);
    reply_t           r;
    logic [63:0]      key;
    logic [63:0]      prod;
    logic [IDX_W-1:0] pos;
    logic [48:0]      total;
    bit               hit;
    bit               vacant;
    int               n;
    r      = '{STAT_NOTFOUND, 48'd0, 32'd0};
    key    = (a < b) ? {a, b} : {b, a};
    hit    = 1'b0;
    vacant = 1'b0;
    pos    = '0;
    if (op == OP_ADD || op == OP_FIND) begin
      prod = key * FIB_MULT;
      pos  = prod[IDX_W-1:0];
      for (n = 0; n < CAPACITY; n++) begin
        if (!occupied[pos]) begin
          vacant = 1'b1;
          break;
        end
        if (stored_key[pos] == key) begin
          hit = 1'b1;
          break;
        end
        pos = pos + 1'b1;
      end
    end
    case (op)
      OP_ADD: begin
        if (hit) begin
          r.status = STAT_UPDATED;
        end else if (vacant && (live_entries + 1) * 10 < CAPACITY * 7) begin
          occupied[pos]     = 1'b1;
          stored_key[pos]   = key;
          stored_sum[pos]   = '0;
          stored_count[pos] = '0;
          live_entries++;
          r.status = STAT_INSERTED;
        end else begin
          r.status = STAT_FULL;
          refusal_total++;
        end
        if (r.status != STAT_FULL) begin
          total = stored_sum[pos] + amt;
          stored_sum[pos] = total[48] ? '1 : total[47:0];
          if (stored_count[pos] != '1) stored_count[pos]++;
          r.sum   = stored_sum[pos];
          r.count = stored_count[pos];
        end
      end
      OP_FIND: begin
        if (hit) begin
          r.status = STAT_UPDATED;
          r.sum    = stored_sum[pos];
          r.count  = stored_count[pos];
        end
      end
      OP_CLEAR: begin
        occupied     = '{default: 1'b0};
        live_entries = 0;
        r.status     = STAT_CLEARED;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      occupied     = '{default: 1'b0};
      live_entries = 0;
      expected_replies.delete();
    end else begin
      if (s_tvalid && s_tready)
        expected_replies.push_back(predict_table_op(s_tdata[1:0], s_tdata[33:2],
                                                    s_tdata[65:34], s_tdata[97:66]));
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[2:0], m_tdata[50:3], m_tdata[82:51]};
        if (expected_replies.size() == 0) begin
          $error("reply with no transaction pending: status %0d", got.status);
          fail_total++;
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, got.status);
            fail_total++;
          end
          if (got.sum !== want.sum) begin
            $error("utility_sum mismatch: expected %h, got %h", want.sum, got.sum);
            fail_total++;
          end
          if (got.count !== want.count) begin
            $error("pair_count mismatch: expected %0d, got %0d", want.count, got.count);
            fail_total++;
          end
        end
      end
    end
    mismatches  <= fail_total;
    outstanding <= expected_replies.size();
    refusals    <= refusal_total;
  end

endmodule

// ===== sim/tb_pair_accumulate_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// tb_pair_accumulate_hash_table_core
// Drives add, find, clear and unused-opcode transactions into the pair hash
// table with random gaps and back-pressure, including a fill past the load
// limit and a back-to-back add burst on one pair; the monitor predicts and
// checks.
// ----------------------------------------------------------------------------
module tb_pair_accumulate_hash_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import paht_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  // back-to-back maximal adds on one pair
  localparam int BURST_ADDS = 60;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;

  int chk_mismatches;
  int chk_outstanding;
  int chk_refusals;

  bit send_idle  = 1'b1;
  bit recv_idle  = 1'b1;
  bit burst_mode = 1'b0;
  int n_sent     = 0;
  int n_add      = 0;
  int n_find     = 0;
  int n_clear    = 0;
  int n_unused   = 0;

  always #5 clk = ~clk;

  pair_accumulate_hash_table_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  pair_table_monitor monitor (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (chk_mismatches),
    .outstanding (chk_outstanding),
    .refusals    (chk_refusals)
  );

  function automatic logic [31:0] rand_id();
    case ($urandom_range(5, 0))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(15, 0);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_amount();
    case ($urandom_range(5, 0))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(32'h0002_0000, 0);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] amt);
    int gap;
    if (n_sent % 40 == 0) send_idle = ($urandom_range(3, 0) != 0);
    gap = (send_idle && !burst_mode) ? $urandom_range(17, 0) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, amt, b, a, op};
    do @(posedge clk); while (!s_tready);
    n_sent++;
    case (op)
      OP_ADD:   n_add++;
      OP_FIND:  n_find++;
      OP_CLEAR: n_clear++;
      default:  n_unused++;
    endcase
  endtask

  // small pool of pairs so adds and finds keep hitting live entries
  task automatic run_mixed(input int count);
    logic [31:0] pool_a[$];
    logic [31:0] pool_b[$];
    logic [31:0] x;
    logic [31:0] y;
    int          k;
    int          pick;
    int          sel;
    for (k = 0; k < 20; k++) begin
      pool_a.push_back(rand_id());
      pool_b.push_back(rand_id());
    end
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(pool_a.size() - 1, 0);
      x    = pool_a[pick];
      y    = pool_b[pick];
      if ($urandom_range(1, 0)) begin
        x = pool_b[pick];
        y = pool_a[pick];
      end
      sel = $urandom_range(99, 0);
      if (sel < 50)      send_item(OP_ADD, x, y, rand_amount());
      else if (sel < 60) send_item(OP_ADD, rand_id(), rand_id(), rand_amount());
      else if (sel < 85) send_item(OP_FIND, x, y, $urandom());
      else if (sel < 94) send_item(OP_FIND, rand_id(), rand_id(), $urandom());
      else if (sel < 97) send_item(OP_UNUSED, $urandom(), $urandom(), $urandom());
      else               send_item(OP_CLEAR, $urandom(), $urandom(), $urandom());
    end
  endtask

  initial begin : receiver
    int stall;
    int taken;
    taken = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken % 40 == 0) recv_idle = ($urandom_range(3, 0) != 0);
      if (burst_mode)                       stall = 0;
      else if (taken == 150 || taken == 900) stall = 400;
      else                                  stall = recv_idle ? $urandom_range(17, 0) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  initial begin : stimulus
    logic [31:0] fill_a[$];
    logic [31:0] fill_b[$];
    int          k;
    int          pick;
    int          sel;
    int          new_pct;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, order independence, unused opcode, clear
    send_item(OP_FIND,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_ADD,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_ADD,    32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_FIND,   32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_FIND,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_FIND,   32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000);
    send_item(OP_ADD,    32'h0000_0005, 32'h0000_0003, 32'h0000_0001);
    send_item(OP_ADD,    32'h0000_0003, 32'h0000_0005, 32'h0000_0002);
    send_item(OP_FIND,   32'h0000_0005, 32'h0000_0003, 32'h0000_0000);
    send_item(OP_ADD,    32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h8000_0001);
    send_item(OP_FIND,   32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0000_0000);
    send_item(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_FIND,   32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    // re-insert after clear must start from a fresh sum and count
    send_item(OP_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0007);
    send_item(OP_CLEAR,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

    run_mixed(300);

    // fill past the load limit, then hammer the full table
    send_item(OP_CLEAR, $urandom(), $urandom(), $urandom());
    for (k = 0; k < 900; k++) begin
      new_pct = (k < 760) ? 94 : 40;
      sel     = $urandom_range(99, 0);
      if (sel < new_pct || fill_a.size() == 0) begin
        fill_a.push_back($urandom());
        fill_b.push_back($urandom());
        send_item(OP_ADD, fill_a[$], fill_b[$], rand_amount());
      end else begin
        pick = $urandom_range(fill_a.size() - 1, 0);
        if (sel < new_pct + (100 - new_pct) / 2)
          send_item(OP_FIND, fill_b[pick], fill_a[pick], $urandom());
        else
          send_item(OP_ADD, fill_a[pick], fill_b[pick], rand_amount());
      end
    end

    run_mixed(400);

    // maximal adds on one pair, back to back
    burst_mode = 1'b1;
    send_item(OP_CLEAR, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    for (k = 0; k < BURST_ADDS; k++)
      send_item(OP_ADD, 32'h0004_0506, 32'h0001_0203, 32'hFFFF_FFFF);
    send_item(OP_FIND, 32'h0001_0203, 32'h0004_0506, 32'h0000_0000);
    burst_mode = 1'b0;

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (chk_outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d transactions: %0d add, %0d find, %0d clear, %0d unused opcode",
             n_sent, n_add, n_find, n_clear, n_unused);
    $display("Load limit refused %0d new pairs; one pair took %0d back-to-back maximal adds",
             chk_refusals, BURST_ADDS);
    if (chk_mismatches == 0 && chk_outstanding == 0) begin
      $display("PASS pair_accumulate_hash_table_core");
    end else begin
      $display("FAIL pair_accumulate_hash_table_core");
    end
    $finish;
  end

  initial begin : watchdog
    #50ms;
    $display("FAIL pair_accumulate_hash_table_core");
    $finish;
  end

endmodule
